### rtl/core/sgs_pkg.sv
// ----------------------------------------------------------------------------
// sgs_pkg: shared types and constants for the scrolling grid store
// Grid geometry, configuration register indexes, action codes and the
// element request that the shift address generator hands to the top level.
// ----------------------------------------------------------------------------
package sgs_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int IDX_W    = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int ADDR_W   = ROW_W + COL_W;
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int WORD_W   = 32;
    localparam int AMT_W    = 8;
    localparam int SRC_W    = ((IDX_W > AMT_W) ? IDX_W : AMT_W) + 2;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_SHROW = 2'd2,
        ACT_SHCOL = 2'd3
    } t_action;

    // one element move of a shift pass
    typedef struct packed {
        logic              valid;
        logic              last;
        logic              zero;
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] dst_addr;
    } t_agu_req;

endpackage

### rtl/core/scrolling_grid_store_unit.sv
// ----------------------------------------------------------------------------
// scrolling_grid_store_unit: scrollable grid of 32-bit words
// Rows and columns in use come from two configuration registers; reads,
// writes and whole-grid shifts work on that part of a 64 by 64 word store.
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_stall carries one request (action, row,
//   column, word, shift amount); output channel: o_out_valid / i_out_stall
//   carries exactly one result (word, out-of-range flag) per request.
//   config: i_cfg_we writes i_cfg_data into register i_cfg_index (0 rows,
//   1 columns); write it only while no request is in flight.
//   flow: a read or write passes through state ST_RESP into the output
//   register; a shift makes one element move per cycle, paced by the
//   single read and single write port of the store.
//   one request is in flight at a time; the next is accepted once the
//   result is in the output register, even while that result waits.
//   reset: synchronous, active low; afterwards the store is cleared to zero
//   one word per cycle over all 4096 words, during which o_in_stall stays high.
//   a stalled output holds its result; a following result waits inside.
// ----------------------------------------------------------------------------
module scrolling_grid_store_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sgs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sgs_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_action,
    input  logic [sgs_pkg::ROW_W-1:0]           i_row_index,
    input  logic [sgs_pkg::COL_W-1:0]           i_col_index,
    input  logic [sgs_pkg::WORD_W-1:0]          i_word_in,
    input  logic signed [sgs_pkg::AMT_W-1:0]    i_shift_amount,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [sgs_pkg::WORD_W-1:0]          o_word_out,
    output logic                                o_out_of_range
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SHIFT,
        ST_RESP
    } t_state;

    t_state                            r_state;
    logic [sgs_pkg::ADDR_W-1:0]        r_clr_addr;
    logic [sgs_pkg::CFG_W-1:0]         r_rows;
    logic [sgs_pkg::CFG_W-1:0]         r_cols;
    logic                              r_res_rd;
    logic                              r_res_oor;
    logic                              r_pipe_valid;
    logic                              r_pipe_last;
    logic                              r_pipe_zero;
    logic [sgs_pkg::ADDR_W-1:0]        r_pipe_dst;
    logic [sgs_pkg::WORD_W-1:0]        r_rd_data;
    logic [sgs_pkg::WORD_W-1:0]        r_mem [0:sgs_pkg::DEPTH-1];

    sgs_pkg::t_action                  w_action;
    sgs_pkg::t_agu_req                 w_agu;
    logic                              w_accept;
    logic [sgs_pkg::CFG_W-1:0]         w_rows_act;
    logic [sgs_pkg::CFG_W-1:0]         w_cols_act;
    logic                              w_in_range;
    logic                              w_is_access;
    logic                              w_is_rows;
    logic [sgs_pkg::CFG_W-1:0]         w_lines;
    logic [sgs_pkg::CFG_W-1:0]         w_span;
    logic                              w_agu_start;
    logic [sgs_pkg::ADDR_W-1:0]        w_addr_in;
    logic                              w_we;
    logic [sgs_pkg::ADDR_W-1:0]        w_waddr;
    logic [sgs_pkg::WORD_W-1:0]        w_wdata;
    logic                              w_re;
    logic [sgs_pkg::ADDR_W-1:0]        w_raddr;

    assign w_action   = sgs_pkg::t_action'(i_action);
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);

    // register values above the grid size saturate
    assign w_rows_act = (r_rows > sgs_pkg::CFG_W'(sgs_pkg::MAX_ROWS))
                      ? sgs_pkg::CFG_W'(sgs_pkg::MAX_ROWS) : r_rows;
    assign w_cols_act = (r_cols > sgs_pkg::CFG_W'(sgs_pkg::MAX_COLS))
                      ? sgs_pkg::CFG_W'(sgs_pkg::MAX_COLS) : r_cols;

    assign w_in_range  = (sgs_pkg::CFG_W'(i_row_index) < w_rows_act)
                      && (sgs_pkg::CFG_W'(i_col_index) < w_cols_act);
    assign w_is_access = (w_action == sgs_pkg::ACT_WRITE) || (w_action == sgs_pkg::ACT_READ);
    assign w_is_rows   = (w_action == sgs_pkg::ACT_SHROW);
    assign w_lines     = w_is_rows ? w_rows_act : w_cols_act;
    assign w_span      = w_is_rows ? w_cols_act : w_rows_act;
    // empty grid: a shift has nothing to move
    assign w_agu_start = w_accept && !w_is_access
                      && (w_rows_act != '0) && (w_cols_act != '0);
    assign w_addr_in   = {i_row_index, i_col_index};

    sgs_agu u_agu (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_agu_start),
        .i_is_rows (w_is_rows),
        .i_amt     (i_shift_amount),
        .i_lines   (w_lines),
        .i_span    (w_span),
        .o_req     (w_agu)
    );

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_addr_in;
        w_wdata = i_word_in;
        priority if (r_state == ST_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
        end else if (r_pipe_valid) begin
            w_we    = 1'b1;
            w_waddr = r_pipe_dst;
            w_wdata = r_pipe_zero ? '0 : r_rd_data;
        end else if (w_accept && (w_action == sgs_pkg::ACT_WRITE) && w_in_range) begin
            w_we = 1'b1;
        end
    end

    assign w_re    = (w_agu.valid && !w_agu.zero)
                  || (w_accept && (w_action == sgs_pkg::ACT_READ) && w_in_range);
    assign w_raddr = w_agu.valid ? w_agu.src_addr : w_addr_in;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    // element move: read issued this cycle, written back the next
    always_ff @(posedge i_clk) begin
        r_pipe_last <= w_agu.last;
        r_pipe_zero <= w_agu.zero;
        r_pipe_dst  <= w_agu.dst_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_rows       <= sgs_pkg::CFG_W'(sgs_pkg::MAX_ROWS);
            r_cols       <= sgs_pkg::CFG_W'(sgs_pkg::MAX_COLS);
            r_pipe_valid <= 1'b0;
            o_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    sgs_pkg::CFG_ROWS: r_rows <= i_cfg_data;
                    sgs_pkg::CFG_COLS: r_cols <= i_cfg_data;
                    default: ;
                endcase
            end
            r_pipe_valid <= w_agu.valid;
            if (o_out_valid && !i_out_stall && (r_state != ST_RESP)) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == sgs_pkg::ADDR_W'(sgs_pkg::DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_accept) begin
                        r_res_rd  <= (w_action == sgs_pkg::ACT_READ) && w_in_range;
                        r_res_oor <= w_is_access && !w_in_range;
                        r_state   <= w_agu_start ? ST_SHIFT : ST_RESP;
                    end
                end
                ST_SHIFT: begin
                    if (r_pipe_valid && r_pipe_last) begin
                        r_state <= ST_RESP;
                    end
                end
                ST_RESP: begin
                    if (!o_out_valid || !i_out_stall) begin
                        o_out_valid    <= 1'b1;
                        o_word_out     <= r_res_rd ? r_rd_data : '0;
                        o_out_of_range <= r_res_oor;
                        r_state        <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_agu_only_in_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_agu.valid |-> (r_state == ST_SHIFT))
        else $error("shift element request outside a shift");

    a_no_read_after_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pipe_valid && w_agu.valid && !w_agu.zero) |-> (r_pipe_dst != w_agu.src_addr))
        else $error("shift reads a word in the cycle it is overwritten");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != ST_IDLE))
        else $error("accepted request did not start");

    a_result_only_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_RESP))
        else $error("result appeared without a finished request");

endmodule

### rtl/core/sgs_agu.sv
// ----------------------------------------------------------------------------
// sgs_agu: shift address generator
// Walks every element of the used grid once per shift, in an order that never
// reads a word after it has been overwritten, and computes each source index
// with one shared subtract and compare.
// ----------------------------------------------------------------------------
module sgs_agu (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_is_rows,
    input  logic signed [sgs_pkg::AMT_W-1:0] i_amt,
    input  logic [sgs_pkg::CFG_W-1:0]        i_lines,
    input  logic [sgs_pkg::CFG_W-1:0]        i_span,
    output sgs_pkg::t_agu_req                o_req
);

    logic                              r_busy;
    logic                              r_desc;
    logic                              r_is_rows;
    logic signed [sgs_pkg::AMT_W-1:0]  r_amt;
    logic [sgs_pkg::CFG_W-1:0]         r_lines;
    logic [sgs_pkg::CFG_W-1:0]         r_span;
    logic [sgs_pkg::IDX_W-1:0]         r_d;
    logic [sgs_pkg::IDX_W-1:0]         r_k;

    logic signed [sgs_pkg::SRC_W-1:0]  w_src;
    logic                              w_zero;
    logic [sgs_pkg::IDX_W-1:0]         w_d_end;
    logic [sgs_pkg::IDX_W-1:0]         w_k_end;
    logic                              w_k_wrap;
    logic                              w_last;
    logic [sgs_pkg::IDX_W-1:0]         w_s;

    // source line for destination line d
    assign w_src  = $signed(sgs_pkg::SRC_W'(r_d)) - sgs_pkg::SRC_W'(r_amt);
    assign w_zero = w_src[sgs_pkg::SRC_W-1]
                 || (w_src[sgs_pkg::SRC_W-2:0] >= (sgs_pkg::SRC_W-1)'(r_lines));
    assign w_s    = w_src[sgs_pkg::IDX_W-1:0];

    assign w_d_end  = r_desc ? '0 : sgs_pkg::IDX_W'(r_lines - 1'b1);
    assign w_k_end  = sgs_pkg::IDX_W'(r_span - 1'b1);
    assign w_k_wrap = (r_k == w_k_end);
    assign w_last   = w_k_wrap && (r_d == w_d_end);

    always_comb begin
        o_req.valid = r_busy;
        o_req.last  = w_last;
        o_req.zero  = w_zero;
        if (r_is_rows) begin
            o_req.dst_addr = {r_d[sgs_pkg::ROW_W-1:0], r_k[sgs_pkg::COL_W-1:0]};
            o_req.src_addr = {w_s[sgs_pkg::ROW_W-1:0], r_k[sgs_pkg::COL_W-1:0]};
        end else begin
            o_req.dst_addr = {r_k[sgs_pkg::ROW_W-1:0], r_d[sgs_pkg::COL_W-1:0]};
            o_req.src_addr = {r_k[sgs_pkg::ROW_W-1:0], w_s[sgs_pkg::COL_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy    <= 1'b1;
            r_is_rows <= i_is_rows;
            r_amt     <= i_amt;
            r_lines   <= i_lines;
            r_span    <= i_span;
            // moving toward higher index: fill from the top line down
            r_desc    <= !i_amt[sgs_pkg::AMT_W-1];
            r_d       <= i_amt[sgs_pkg::AMT_W-1] ? '0 : sgs_pkg::IDX_W'(i_lines - 1'b1);
            r_k       <= '0;
        end else if (r_busy) begin
            if (w_last) begin
                r_busy <= 1'b0;
            end else if (w_k_wrap) begin
                r_k <= '0;
                r_d <= r_desc ? r_d - 1'b1 : r_d + 1'b1;
            end else begin
                r_k <= r_k + 1'b1;
            end
        end
    end

endmodule
